// File: src/pool2d_pkg.sv
// ----------------------------------------------------------------------------
// pool2d_pkg
// Shared types, register codes, reset values and small arithmetic helpers
// for the streaming 2-D max/average pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package pool2d_pkg;

  // Default build sizes
  localparam int unsigned MAX_COLS_DEF    = 512;
  localparam int unsigned MAX_KERNEL_DEF  = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 17;
  localparam int unsigned KSIZE_BITS    = 4;
  localparam int unsigned IMG_BITS      = 10;
  localparam int unsigned RECIP_BITS    = 17;
  localparam int unsigned RECIP_FRAC    = 16;
  localparam int unsigned POS_BITS      = 9;
  localparam int unsigned ROW_BITS      = 9;
  localparam int unsigned ROW_LIMIT     = 512;
  localparam int unsigned DIV_BITS      = 13;

  // Register reset values
  localparam int unsigned KERNEL_H_RST = 2;
  localparam int unsigned KERNEL_W_RST = 2;
  localparam int unsigned IMG_W_RST    = 512;
  localparam int unsigned IMG_H_RST    = 512;
  localparam int unsigned RECIP_RST    = 16384;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POOL_MODE  = 3'd0,
    REG_KERNEL_H   = 3'd1,
    REG_KERNEL_W   = 3'd2,
    REG_IMAGE_W    = 3'd3,
    REG_IMAGE_H    = 3'd4,
    REG_AVG_RECIP  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_AVG = 1'b1
  } pool_mode_e;

  // Per-sample window flags, worked out from the position counters
  typedef struct packed {
    logic in_window;
    logic first;
    logic ends;
    logic last;
  } item_ctx_t;

  typedef struct packed {
    pool_mode_e             mode;
    logic [RECIP_BITS-1:0]  recip;
  } avg_cfg_t;

  // Zero reads as one, anything above hi reads as hi
  function automatic logic [DIV_BITS-1:0] clamp_val(logic [DIV_BITS-1:0] v,
                                                    int unsigned hi);
    logic [DIV_BITS-1:0] r;
    if (v == '0) begin
      r = DIV_BITS'(1);
    end else if (32'(v) > hi) begin
      r = DIV_BITS'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // floor(v / k) for k in 1..15 by a Q1.16 reciprocal, exact for v < 4096
  function automatic logic [DIV_BITS-1:0] div_small(logic [DIV_BITS-1:0] v,
                                                    logic [KSIZE_BITS-1:0] k);
    logic [RECIP_BITS-1:0]          m;
    logic [DIV_BITS+RECIP_BITS-1:0] prod;
    case (k)
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      4'd10:   m = 17'd6554;
      4'd11:   m = 17'd5958;
      4'd12:   m = 17'd5462;
      4'd13:   m = 17'd5042;
      4'd14:   m = 17'd4682;
      4'd15:   m = 17'd4370;
      default: m = 17'd65536;
    endcase
    prod = (DIV_BITS+RECIP_BITS)'(v) * (DIV_BITS+RECIP_BITS)'(m);
    return prod[RECIP_FRAC +: DIV_BITS];
  endfunction

endpackage

`default_nettype wire

// File: src/pool2d_ram.sv
// ----------------------------------------------------------------------------
// pool2d_ram
// Generic single-write, single-read RAM with registered read data.
// A read and write to the same address in one cycle returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module pool2d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrBits = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]    wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/pool2d_ctrl.sv
// ----------------------------------------------------------------------------
// pool2d_ctrl
// Configuration registers, derived window counts and raster position
// counters. Gives the partial-store address and window flags of the
// sample currently offered at the input.
// ----------------------------------------------------------------------------
`default_nettype none

module pool2d_ctrl import pool2d_pkg::*; #(
  parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
  parameter int unsigned MAX_KERNEL = MAX_KERNEL_DEF,
  localparam int unsigned ColBits = $clog2(MAX_COLS),
  localparam int unsigned KBits   = $clog2(MAX_KERNEL)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     accept_i,
  output item_ctx_t                     ctx_o,
  output logic      [ColBits-1:0]       rd_addr_o,
  output logic      [KBits-1:0]         wro_o,
  output logic      [KBits-1:0]         wco_o,
  output logic      [POS_BITS-1:0]      base_row_o,
  output logic      [POS_BITS-1:0]      base_col_o,
  output avg_cfg_t                      avg_cfg_o
);

  localparam int unsigned WBits   = ColBits + 1;
  localparam int unsigned RLBits  = IMG_BITS + KSIZE_BITS;
  localparam int unsigned OffBits = KSIZE_BITS + 1;
  localparam int unsigned RstW    = (IMG_W_RST > MAX_COLS) ? MAX_COLS : IMG_W_RST;
  localparam int unsigned RstCols = RstW / KERNEL_W_RST;
  localparam int unsigned RstQH   = IMG_H_RST / KERNEL_H_RST;

  pool_mode_e            mode_q, mode_d;
  logic [KSIZE_BITS-1:0] kh_q, kh_d, kw_q, kw_d;
  logic [IMG_BITS-1:0]   imw_q, imw_d, imh_q, imh_d;
  logic [RECIP_BITS-1:0] recip_q, recip_d;
  logic [WBits-1:0]      cols_q, cols_d;
  logic [IMG_BITS-1:0]   quot_h_q, quot_h_d;

  logic [ColBits-1:0]    cp_q, cp_d, oc_q, oc_d;
  logic [ROW_BITS-1:0]   rp_q, rp_d;
  logic [KBits-1:0]      wco_q, wco_d, wro_q, wro_d;

  logic [KSIZE_BITS-1:0] kh_c, kw_c;
  logic [WBits-1:0]      w_c;
  logic [IMG_BITS-1:0]   h_c;
  logic [RLBits-1:0]     row_lim;
  logic                  col_wrap, row_wrap, wco_wrap, wro_wrap;

  // Register writes
  always_comb begin
    mode_d  = mode_q;
    kh_d    = kh_q;
    kw_d    = kw_q;
    imw_d   = imw_q;
    imh_d   = imh_q;
    recip_d = recip_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POOL_MODE: mode_d  = pool_mode_e'(cfg_data_i[0]);
        REG_KERNEL_H:  kh_d    = cfg_data_i[KSIZE_BITS-1:0];
        REG_KERNEL_W:  kw_d    = cfg_data_i[KSIZE_BITS-1:0];
        REG_IMAGE_W:   imw_d   = cfg_data_i[IMG_BITS-1:0];
        REG_IMAGE_H:   imh_d   = cfg_data_i[IMG_BITS-1:0];
        REG_AVG_RECIP: recip_d = cfg_data_i[RECIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Output columns and output rows follow the new register values at once
  assign cols_d = WBits'(div_small(
                    clamp_val(DIV_BITS'(imw_d), MAX_COLS),
                    KSIZE_BITS'(clamp_val(DIV_BITS'(kw_d), MAX_KERNEL))));
  assign quot_h_d = IMG_BITS'(div_small(
                      clamp_val(DIV_BITS'(imh_d), ROW_LIMIT),
                      KSIZE_BITS'(clamp_val(DIV_BITS'(kh_d), MAX_KERNEL))));

  assign kh_c = KSIZE_BITS'(clamp_val(DIV_BITS'(kh_q), MAX_KERNEL));
  assign kw_c = KSIZE_BITS'(clamp_val(DIV_BITS'(kw_q), MAX_KERNEL));
  assign w_c  = WBits'(clamp_val(DIV_BITS'(imw_q), MAX_COLS));
  assign h_c  = IMG_BITS'(clamp_val(DIV_BITS'(imh_q), ROW_LIMIT));

  // Rows below the last whole window band are read but pooled into nothing
  assign row_lim = RLBits'(quot_h_q) * RLBits'(kh_c);

  assign col_wrap = (WBits'(cp_q) + WBits'(1)) >= w_c;
  assign row_wrap = (IMG_BITS'(rp_q) + IMG_BITS'(1)) >= h_c;
  assign wco_wrap = (OffBits'(wco_q) + OffBits'(1)) >= OffBits'(kw_c);
  assign wro_wrap = (OffBits'(wro_q) + OffBits'(1)) >= OffBits'(kh_c);

  always_comb begin
    ctx_o.in_window = (WBits'(oc_q) < cols_q) && (RLBits'(rp_q) < row_lim);
    ctx_o.first     = (wro_q == '0) && (wco_q == '0);
    ctx_o.ends      = wro_wrap && wco_wrap;
    ctx_o.last      = ((RLBits'(rp_q) + RLBits'(1)) >= row_lim) &&
                      ((WBits'(oc_q) + WBits'(1)) >= cols_q);
  end

  assign rd_addr_o  = oc_q;
  assign wro_o      = wro_q;
  assign wco_o      = wco_q;
  assign base_row_o = rp_q - ROW_BITS'(wro_q);
  assign base_col_o = POS_BITS'(cp_q) - POS_BITS'(wco_q);
  assign avg_cfg_o.mode  = mode_q;
  assign avg_cfg_o.recip = recip_q;

  // Advance the raster position on every transfer
  always_comb begin
    cp_d  = cp_q;
    oc_d  = oc_q;
    rp_d  = rp_q;
    wco_d = wco_q;
    wro_d = wro_q;
    if (accept_i) begin
      if (col_wrap) begin
        cp_d  = '0;
        wco_d = '0;
        oc_d  = '0;
        if (row_wrap) begin
          rp_d  = '0;
          wro_d = '0;
        end else begin
          rp_d  = rp_q + ROW_BITS'(1);
          wro_d = wro_wrap ? '0 : wro_q + KBits'(1);
        end
      end else begin
        cp_d = cp_q + ColBits'(1);
        if (wco_wrap) begin
          wco_d = '0;
          oc_d  = oc_q + ColBits'(1);
        end else begin
          wco_d = wco_q + KBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MAX;
      kh_q     <= KSIZE_BITS'(KERNEL_H_RST);
      kw_q     <= KSIZE_BITS'(KERNEL_W_RST);
      imw_q    <= IMG_BITS'(IMG_W_RST);
      imh_q    <= IMG_BITS'(IMG_H_RST);
      recip_q  <= RECIP_BITS'(RECIP_RST);
      cols_q   <= WBits'(RstCols);
      quot_h_q <= IMG_BITS'(RstQH);
      cp_q     <= '0;
      oc_q     <= '0;
      rp_q     <= '0;
      wco_q    <= '0;
      wro_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      kh_q     <= kh_d;
      kw_q     <= kw_d;
      imw_q    <= imw_d;
      imh_q    <= imh_d;
      recip_q  <= recip_d;
      cols_q   <= cols_d;
      quot_h_q <= quot_h_d;
      cp_q     <= cp_d;
      oc_q     <= oc_d;
      rp_q     <= rp_d;
      wco_q    <= wco_d;
      wro_q    <= wro_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pool2d_core.sv
// ----------------------------------------------------------------------------
// pool2d_core
// Input register, per-column partial store with write-to-read bypass,
// max/sum update, average scaling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pool2d_core import pool2d_pkg::*; #(
  parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
  parameter int unsigned MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned AddrBits = $clog2(MAX_COLS),
  localparam int unsigned KBits    = $clog2(MAX_KERNEL)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire item_ctx_t                     ctx_i,
  input  wire logic        [AddrBits-1:0]    rd_addr_i,
  input  wire logic        [KBits-1:0]       wro_i,
  input  wire logic        [KBits-1:0]       wco_i,
  input  wire logic        [POS_BITS-1:0]    base_row_i,
  input  wire logic        [POS_BITS-1:0]    base_col_i,
  input  wire avg_cfg_t                      avg_cfg_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed      [SAMPLE_BITS-1:0] pooled_value_o,
  output logic             [POS_BITS-1:0]    arg_row_o,
  output logic             [POS_BITS-1:0]    arg_col_o,
  output logic                               plane_last_o
);

  localparam int unsigned VBits    = SAMPLE_BITS + 2 * KBits;
  localparam int unsigned EntBits  = VBits + 2 * KBits;
  localparam int unsigned ProdBits = VBits + RECIP_BITS + 1;
  localparam logic signed [ProdBits-1:0] SatHi =
    ProdBits'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ProdBits-1:0] SatLo = ~SatHi;

  // Input register
  logic                          s1_valid_q;
  item_ctx_t                     s1_ctx_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [AddrBits-1:0]           s1_addr_q;
  logic [KBits-1:0]              s1_wro_q, s1_wco_q;
  logic [POS_BITS-1:0]           s1_brow_q, s1_bcol_q;
  logic                          fwd_hit_q;
  logic [EntBits-1:0]            fwd_q;

  // Result register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [POS_BITS-1:0]           out_row_q, out_col_q;
  logic                          out_last_q;

  logic [EntBits-1:0]            ram_rdata, old_ent, new_ent;
  logic signed [VBits-1:0]       old_val, new_val, x_ext;
  logic [KBits-1:0]              old_ar, old_ac, new_ar, new_ac;
  logic signed [RECIP_BITS:0]    recip_s;
  logic signed [ProdBits-1:0]    prod, scaled;
  logic signed [SAMPLE_BITS-1:0] avg_val, res_val;
  logic [POS_BITS-1:0]           res_row, res_col;
  logic                          emit, advance, s1_done, wr_en;

  assign emit    = s1_valid_q && s1_ctx_q.in_window && s1_ctx_q.ends;
  assign advance = !out_valid_q || out_ready_i;
  assign s1_done = s1_valid_q && (!emit || advance);
  assign wr_en   = s1_done && s1_ctx_q.in_window;

  assign in_ready_o = !s1_valid_q || s1_done;

  pool2d_ram #(
    .WIDTH (EntBits),
    .DEPTH (MAX_COLS)
  ) u_partial_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_ent),
    .re_i    (accept_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // Take the entry written in the cycle of the read if the read missed it
  assign old_ent = fwd_hit_q ? fwd_q : ram_rdata;
  assign old_val = $signed(old_ent[EntBits-1 -: VBits]);
  assign old_ar  = old_ent[2*KBits-1 -: KBits];
  assign old_ac  = old_ent[KBits-1:0];
  assign x_ext   = VBits'(s1_sample_q);

  always_comb begin
    new_val = old_val;
    new_ar  = old_ar;
    new_ac  = old_ac;
    if (s1_ctx_q.first) begin
      new_val = x_ext;
      new_ar  = '0;
      new_ac  = '0;
    end else if (avg_cfg_i.mode == MODE_MAX) begin
      // strict compare: the earlier sample keeps a tie
      if (x_ext > old_val) begin
        new_val = x_ext;
        new_ar  = s1_wro_q;
        new_ac  = s1_wco_q;
      end
    end else begin
      new_val = old_val + x_ext;
    end
  end

  assign new_ent = {new_val, new_ar, new_ac};

  // Average: floor(sum * recip / 2^16), saturated to the sample range
  assign recip_s = $signed({1'b0, avg_cfg_i.recip});
  assign prod    = ProdBits'(new_val) * ProdBits'(recip_s);
  assign scaled  = prod >>> RECIP_FRAC;

  always_comb begin
    if (scaled > SatHi) begin
      avg_val = SAMPLE_BITS'(SatHi);
    end else if (scaled < SatLo) begin
      avg_val = SAMPLE_BITS'(SatLo);
    end else begin
      avg_val = SAMPLE_BITS'(scaled);
    end
  end

  always_comb begin
    if (avg_cfg_i.mode == MODE_MAX) begin
      res_val = new_val[SAMPLE_BITS-1:0];
      res_row = s1_brow_q + POS_BITS'(new_ar);
      res_col = s1_bcol_q + POS_BITS'(new_ac);
    end else begin
      res_val = avg_val;
      res_row = '0;
      res_col = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_ctx_q    <= '0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
        s1_ctx_q   <= ctx_i;
        fwd_hit_q  <= wr_en && (s1_addr_q == rd_addr_i);
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_done && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_sample_q <= sample_i;
      s1_addr_q   <= rd_addr_i;
      s1_wro_q    <= wro_i;
      s1_wco_q    <= wco_i;
      s1_brow_q   <= base_row_i;
      s1_bcol_q   <= base_col_i;
      fwd_q       <= new_ent;
    end
    if (s1_done && emit) begin
      out_value_q <= res_val;
      out_row_q   <= res_row;
      out_col_q   <= res_col;
      out_last_q  <= s1_ctx_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pooled_value_o = out_value_q;
  assign arg_row_o      = out_row_q;
  assign arg_col_o      = out_col_q;
  assign plane_last_o   = out_last_q;

endmodule

`default_nettype wire

// File: src/pool_2d_max_avg_stream.sv
// ----------------------------------------------------------------------------
// pool_2d_max_avg_stream
// Streaming 2-D max or average pooling over non-overlapping windows.
// ----------------------------------------------------------------------------
// Samples of one plane arrive in raster order and are taken at one per clock
// for as long as the result side keeps up; the input stalls only while a
// finished result sits in the output register and is not taken. Each
// sample is pooled into a per-output-column partial entry held in a
// MAX_COLS-deep RAM: the entry is read in the transfer cycle and updated and
// written back as the sample leaves the input register, with a bypass for
// back-to-back hits on the same column. With a window's bottom right
// sample the result goes to the output register. Max mode gives the window
// maximum and the absolute row and column of its first occurrence; average
// mode gives floor(sum * avg_reciprocal / 65536), saturated, with zero
// row and column. Rows and columns that do not fill a whole window give
// nothing. The RAM is not cleared after reset; every entry is written by a
// window's first sample before it is read. Registers are written through
// a plain write port and must only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pool_2d_max_avg_stream import pool2d_pkg::*; #(
  parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
  parameter int unsigned MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic        [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed      [SAMPLE_BITS-1:0] pooled_value_o,
  output logic             [POS_BITS-1:0]    arg_row_o,
  output logic             [POS_BITS-1:0]    arg_col_o,
  output logic                               plane_last_o
);

  localparam int unsigned ColBits = $clog2(MAX_COLS);
  localparam int unsigned KBits   = $clog2(MAX_KERNEL);

  item_ctx_t           ctx;
  logic [ColBits-1:0]  rd_addr;
  logic [KBits-1:0]    wro, wco;
  logic [POS_BITS-1:0] base_row, base_col;
  avg_cfg_t            avg_cfg;
  logic                accept;

  assign accept = in_valid_i && in_ready_o;

  pool2d_ctrl #(
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .ctx_o      (ctx),
    .rd_addr_o  (rd_addr),
    .wro_o      (wro),
    .wco_o      (wco),
    .base_row_o (base_row),
    .base_col_o (base_col),
    .avg_cfg_o  (avg_cfg)
  );

  pool2d_core #(
    .MAX_COLS    (MAX_COLS),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .ctx_i          (ctx),
    .rd_addr_i      (rd_addr),
    .wro_i          (wro),
    .wco_i          (wco),
    .base_row_i     (base_row),
    .base_col_i     (base_col),
    .avg_cfg_i      (avg_cfg),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pooled_value_o (pooled_value_o),
    .arg_row_o      (arg_row_o),
    .arg_col_o      (arg_col_o),
    .plane_last_o   (plane_last_o)
  );

`ifndef SYNTHESIS
  // The input only stalls behind a result that is held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // The partial-store column moves only on a transfer
  a_addr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(rd_addr))
    else $error("column address moved without a transfer");

  // The window column offset steps by one or restarts
  a_wco_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((wco == '0) || (wco == KBits'($past(wco) + 1'b1))))
    else $error("window column offset skipped");
`endif

endmodule

`default_nettype wire
